// File: design/rfor_pkg.sv
// Shared types and codes for the rectangle fill and outline rasterizer.
package rfor_pkg;

   localparam int FIELD_W = 20;
   localparam int BYTE_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_RECT = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [7:0] KIND_FILLED = 8'd82;
   localparam logic [7:0] KIND_OUTLINE = 8'd114;

   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKGROUND = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP_XHI,
      ST_PREP_XLO,
      ST_PREP_XHB,
      ST_PREP_YHI,
      ST_PREP_YLO,
      ST_PREP_YHB,
      ST_ROW,
      ST_PIX,
      ST_RDMEM,
      ST_RDOUT
   } state_type;

endpackage

// File: design/rectangle_fill_outline_rasterizer.sv
// Rectangle fill and outline rasterizer over a byte frame memory: top level.
//
// Operations start on start while busy is low; the single result of each
// operation appears on rsp_valid for one cycle and cannot be held off. A clear
// sweeps the whole canvas; a draw first sets up the rectangle bounds in six
// steps on the shared adder and then sweeps the canvas. The sweep runs the row
// test state once per row and then visits the pixels of that row one by one,
// as the frame memory has a single write port. A read passes through ST_RDMEM
// and ST_RDOUT (registered memory read). A rejected draw, a read outside the
// canvas and the unused operation code never raise busy. The result strobe is
// high in the first cycle with busy low again, or in the cycle right after the
// beat for the operations that keep busy low.
// The frame memory is not cleared after reset; pixels read back before a
// clear or draw hold arbitrary values.
module rectangle_fill_outline_rasterizer
   import rfor_pkg::*;
#(
   parameter int MAX_SIDE = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [BYTE_W-1:0]            req_shape_kind,
   input  logic signed [FIELD_W-1:0]    req_left_x,
   input  logic signed [FIELD_W-1:0]    req_top_y,
   input  logic signed [FIELD_W-1:0]    req_rect_width,
   input  logic signed [FIELD_W-1:0]    req_rect_height,
   input  logic [BYTE_W-1:0]            req_paint_char,
   input  logic [BYTE_W-1:0]            req_read_col,
   input  logic [BYTE_W-1:0]            req_read_row,
   output logic                         rsp_valid,
   output logic [BYTE_W-1:0]            rsp_pixel_char,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CB = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = CB + FRAC_BITS;
   localparam int CW = (PW + 1 > FIELD_W + 2) ? PW + 1 : FIELD_W + 2;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] NEG_ONE = -ONE;

   function automatic logic [SW-1:0] clamp_side(input logic [CSR_DATA_W-1:0] v);
      logic [SW-1:0] s;
      if (v == '0) begin
         s = SW'(1);
      end else if (int'(v) > MAX_SIDE) begin
         s = SW'(MAX_SIDE);
      end else begin
         s = SW'(v);
      end
      return s;
   endfunction

   function automatic logic signed [CW-1:0] to_pos(input logic [CB-1:0] v);
      logic [CW-1:0] t;
      t = CW'(v);
      return signed'(t << FRAC_BITS);
   endfunction

   state_type state_ff, state_in;

   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] height_ff, height_in;
   logic [BYTE_W-1:0] bg_ff, bg_in;

   logic signed [CW-1:0] lx_ff, lx_in, ty_ff, ty_in, w_ff, w_in, h_ff, h_in;
   logic signed [CW-1:0] x_hi_ff, x_hi_in, x_lob_ff, x_lob_in, x_hib_ff, x_hib_in;
   logic signed [CW-1:0] y_hi_ff, y_hi_in, y_lob_ff, y_lob_in, y_hib_ff, y_hib_in;
   logic [BYTE_W-1:0] paint_ff, paint_in;
   logic clear_ff, clear_in, outline_ff, outline_in;
   logic y_in_ff, y_in_in, y_bd_ff, y_bd_in;
   logic [CB-1:0] row_ff, row_in, col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;
   logic [BYTE_W-1:0] rd_col_ff, rd_col_in, rd_row_ff, rd_row_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic [BYTE_W-1:0] mem [DEPTH];

   logic signed [CW-1:0] add_a, add_b, sum;
   logic signed [CW-1:0] cmp_pos, cmp_lo, cmp_hi, cmp_lob, cmp_hib;
   logic c_in, c_bd, hit, last_col, last_row, bad_rect, outside;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_char = rsp_pixel_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      case (state_ff)
         ST_PREP_XHI: begin
            add_a = lx_ff;
            add_b = w_ff;
         end
         ST_PREP_XLO: begin
            add_a = lx_ff;
            add_b = ONE;
         end
         ST_PREP_XHB: begin
            add_a = x_hi_ff;
            add_b = NEG_ONE;
         end
         ST_PREP_YHI: begin
            add_a = ty_ff;
            add_b = h_ff;
         end
         ST_PREP_YLO: begin
            add_a = ty_ff;
            add_b = ONE;
         end
         ST_PREP_YHB: begin
            add_a = y_hi_ff;
            add_b = NEG_ONE;
         end
         default: begin
            add_a = lx_ff;
            add_b = w_ff;
         end
      endcase
      sum = add_a + add_b;
   end

   always_comb begin
      if (state_ff == ST_ROW) begin
         cmp_pos = to_pos(row_ff);
         cmp_lo = ty_ff;
         cmp_hi = y_hi_ff;
         cmp_lob = y_lob_ff;
         cmp_hib = y_hib_ff;
      end else begin
         cmp_pos = to_pos(col_ff);
         cmp_lo = lx_ff;
         cmp_hi = x_hi_ff;
         cmp_lob = x_lob_ff;
         cmp_hib = x_hib_ff;
      end
      c_in = (cmp_pos >= cmp_lo) && (cmp_pos <= cmp_hi);
      c_bd = (cmp_pos < cmp_lob) || (cmp_pos > cmp_hib);
   end

   assign hit = clear_ff || (y_in_ff && c_in && (!outline_ff || y_bd_ff || c_bd));
   assign last_col = ((SW'(col_ff) + SW'(1)) == width_ff);
   assign last_row = ((SW'(row_ff) + SW'(1)) == height_ff);
   assign bad_rect = req_rect_width[FIELD_W-1] || (req_rect_width == '0) ||
                     req_rect_height[FIELD_W-1] || (req_rect_height == '0) ||
                     ((req_shape_kind != KIND_FILLED) && (req_shape_kind != KIND_OUTLINE));
   assign outside = (int'(req_read_col) >= int'(width_ff)) ||
                    (int'(req_read_row) >= int'(height_ff));
   assign wr_en = (state_ff == ST_PIX) && hit;
   assign wr_addr = base_ff + AW'(col_ff);
   assign rd_addr = AW'(int'(rd_row_ff) * MAX_SIDE + int'(rd_col_ff));

   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      height_in = height_ff;
      bg_in = bg_ff;
      lx_in = lx_ff;
      ty_in = ty_ff;
      w_in = w_ff;
      h_in = h_ff;
      x_hi_in = x_hi_ff;
      x_lob_in = x_lob_ff;
      x_hib_in = x_hib_ff;
      y_hi_in = y_hi_ff;
      y_lob_in = y_lob_ff;
      y_hib_in = y_hib_ff;
      paint_in = paint_ff;
      clear_in = clear_ff;
      outline_in = outline_ff;
      y_in_in = y_in_ff;
      y_bd_in = y_bd_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_in = base_ff;
      rd_col_in = rd_col_ff;
      rd_row_in = rd_row_ff;
      rsp_valid_in = 1'b0;
      rsp_pixel_in = '0;
      rsp_status_in = STATUS_OK;

      if (csr_valid) begin
         case (csr_addr)
            CSR_WIDTH: width_in = clamp_side(csr_wdata);
            CSR_HEIGHT: height_in = clamp_side(csr_wdata);
            CSR_BACKGROUND: bg_in = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lx_in = CW'(req_left_x);
               ty_in = CW'(req_top_y);
               w_in = CW'(req_rect_width);
               h_in = CW'(req_rect_height);
               paint_in = req_paint_char;
               outline_in = (req_shape_kind == KIND_OUTLINE);
               clear_in = 1'b0;
               rd_col_in = req_read_col;
               rd_row_in = req_read_row;
               row_in = '0;
               col_in = '0;
               base_in = '0;
               case (req_operation)
                  OP_CLEAR: begin
                     clear_in = 1'b1;
                     paint_in = bg_ff;
                     state_in = ST_ROW;
                  end
                  OP_DRAW: begin
                     if (bad_rect) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STATUS_BAD_RECT;
                     end else begin
                        state_in = ST_PREP_XHI;
                     end
                  end
                  OP_READ: begin
                     if (outside) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STATUS_OUTSIDE;
                     end else begin
                        state_in = ST_RDMEM;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PREP_XHI: begin
            x_hi_in = sum;
            state_in = ST_PREP_XLO;
         end
         ST_PREP_XLO: begin
            x_lob_in = sum;
            state_in = ST_PREP_XHB;
         end
         ST_PREP_XHB: begin
            x_hib_in = sum;
            state_in = ST_PREP_YHI;
         end
         ST_PREP_YHI: begin
            y_hi_in = sum;
            state_in = ST_PREP_YLO;
         end
         ST_PREP_YLO: begin
            y_lob_in = sum;
            state_in = ST_PREP_YHB;
         end
         ST_PREP_YHB: begin
            y_hib_in = sum;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            y_in_in = c_in;
            y_bd_in = c_bd;
            state_in = ST_PIX;
         end
         ST_PIX: begin
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + CB'(1);
                  base_in = base_ff + AW'(MAX_SIDE);
                  state_in = ST_ROW;
               end
            end else begin
               col_in = col_ff + CB'(1);
            end
         end
         ST_RDMEM: begin
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = rd_data_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= SW'(1);
         height_ff <= SW'(1);
         bg_ff <= 8'd32;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         bg_ff <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lx_ff <= lx_in;
      ty_ff <= ty_in;
      w_ff <= w_in;
      h_ff <= h_in;
      x_hi_ff <= x_hi_in;
      x_lob_ff <= x_lob_in;
      x_hib_ff <= x_hib_in;
      y_hi_ff <= y_hi_in;
      y_lob_ff <= y_lob_in;
      y_hib_ff <= y_hib_in;
      paint_ff <= paint_in;
      clear_ff <= clear_in;
      outline_ff <= outline_in;
      y_in_ff <= y_in_in;
      y_bd_ff <= y_bd_in;
      row_ff <= row_in;
      col_ff <= col_in;
      base_ff <= base_in;
      rd_col_ff <= rd_col_in;
      rd_row_ff <= rd_row_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= paint_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
